@@ design/dctt_pkg.sv @@
// Shared types and constants for the debounced cue trigger timer.
`timescale 1ns / 1ps
`default_nettype none

package dctt_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DB_W     = 16;
    localparam int TM_W     = 24;

    // Request classes handed from the front to the back
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_TRIG = 2'd1;
    localparam logic [1:0] KIND_NOP  = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_TRIG = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_ACTIVE   = 2'd1;
    localparam logic [1:0] REG_LEVEL    = 2'd2;
    localparam logic [1:0] REG_ENABLE   = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CHANNELS-1:0] buttons;
        logic [CH_W-1:0]     index;
    } item_t;

    typedef struct packed {
        logic [DB_W-1:0]     debounce_ticks;
        logic [TM_W-1:0]     active_ticks;
        logic                active_level;
        logic [CHANNELS-1:0] enable;
    } cfg_t;

endpackage

`default_nettype wire

@@ design/dctt_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module dctt_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire logic             command,
    input  wire logic [7:0]       buttons,
    input  wire logic [2:0]       trigger_index,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output dctt_pkg::item_t       q_item
);
    import dctt_pkg::*;

    item_t       fifo_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    item_t       item_in;

    assign cmd_ready = (count_reg != 2'd2);
    assign push      = cmd_valid && cmd_ready;
    assign q_valid   = (count_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_item    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.buttons = buttons[CHANNELS-1:0];
        item_in.index   = trigger_index[CH_W-1:0];
        if (command == CMD_TRIG)
        begin
            // drop triggers for channels that do not exist
            if ({1'b0, trigger_index} < 4'(CHANNELS))
                item_in.kind = KIND_TRIG;
            else
                item_in.kind = KIND_NOP;
        end
        else
        begin
            item_in.kind = KIND_TICK;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/dctt_back.sv @@
// Back end: walks the channels for each queued tick request and serializes the cue events.
`timescale 1ns / 1ps
`default_nettype none

module dctt_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dctt_pkg::cfg_t   cfg,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire dctt_pkg::item_t  q_item,
    output logic                  evt_valid,
    input  wire logic             evt_ready,
    output logic [2:0]            event_channel,
    output logic                  event_active,
    output logic [7:0]            active_mask,
    output logic                  last
);
    import dctt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXP   = 2'd1;
    localparam logic [1:0] ST_DEB   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [CHANNELS-1:0] buttons_reg, buttons_next;
    logic                primed_reg, primed_next;
    logic [CHANNELS-1:0] last_level_reg, last_level_next;
    logic [CHANNELS-1:0] stable_level_reg, stable_level_next;
    logic [DB_W-1:0]     debounce_count_reg [CHANNELS];
    logic [DB_W-1:0]     debounce_count_next [CHANNELS];
    logic [CHANNELS-1:0] cue_active_reg, cue_active_next;
    logic [TM_W-1:0]     cue_elapsed_reg [CHANNELS];
    logic [TM_W-1:0]     cue_elapsed_next [CHANNELS];

    logic                pend_valid_reg, pend_valid_next;
    logic [CH_W-1:0]     pend_ch_reg, pend_ch_next;
    logic                pend_act_reg, pend_act_next;
    logic [CHANNELS-1:0] pend_mask_reg, pend_mask_next;

    logic                out_valid_reg, out_valid_next;
    logic [CH_W-1:0]     out_ch_reg, out_ch_next;
    logic                out_act_reg, out_act_next;
    logic [CHANNELS-1:0] out_mask_reg, out_mask_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic                stall;
    logic                evt_fire;
    logic [CH_W-1:0]     evt_ch;
    logic                evt_act;
    logic                out_load;
    logic                out_load_last;
    logic [TM_W-1:0]     el_cur, el_inc;
    logic [DB_W-1:0]     db_cur, db_inc, db_new;
    logic                lv;
    logic                expire;
    logic                level_moved;
    logic                take_stable;
    logic                cue_hit;

    assign evt_valid     = out_valid_reg;
    assign event_channel = 3'(out_ch_reg);
    assign event_active  = out_act_reg;
    assign active_mask   = 8'(out_mask_reg);
    assign last          = out_last_reg;

    assign out_free = !out_valid_reg || evt_ready;
    assign stall    = pend_valid_reg && !out_free;

    // Per-channel datapath for the channel under work
    always_comb
    begin
        el_cur      = cue_elapsed_reg[ch_reg];
        el_inc      = (el_cur == '1) ? el_cur : el_cur + TM_W'(1);
        expire      = cue_active_reg[ch_reg] && (el_inc >= cfg.active_ticks);
        db_cur      = debounce_count_reg[ch_reg];
        db_inc      = (db_cur == '1) ? db_cur : db_cur + DB_W'(1);
        lv          = buttons_reg[ch_reg];
        level_moved = (lv != last_level_reg[ch_reg]);
        db_new      = level_moved ? '0 : db_inc;
        take_stable = cfg.enable[ch_reg] && (db_new >= cfg.debounce_ticks)
                      && (lv != stable_level_reg[ch_reg]);
        cue_hit     = take_stable && (lv == cfg.active_level);
    end

    always_comb
    begin
        state_next        = state_reg;
        ch_next           = ch_reg;
        buttons_next      = buttons_reg;
        primed_next       = primed_reg;
        last_level_next   = last_level_reg;
        stable_level_next = stable_level_reg;
        debounce_count_next = debounce_count_reg;
        cue_active_next   = cue_active_reg;
        cue_elapsed_next  = cue_elapsed_reg;
        pend_valid_next   = pend_valid_reg;
        pend_ch_next      = pend_ch_reg;
        pend_act_next     = pend_act_reg;
        pend_mask_next    = pend_mask_reg;
        out_valid_next    = out_valid_reg;
        out_ch_next       = out_ch_reg;
        out_act_next      = out_act_reg;
        out_mask_next     = out_mask_reg;
        out_last_next     = out_last_reg;
        q_ready           = 1'b0;
        evt_fire          = 1'b0;
        evt_ch            = ch_reg;
        evt_act           = 1'b0;
        out_load          = 1'b0;
        out_load_last     = 1'b0;

        if (out_valid_reg && evt_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    case (q_item.kind)
                        KIND_TRIG:
                        begin
                            cue_active_next[q_item.index]  = 1'b1;
                            cue_elapsed_next[q_item.index] = '0;
                            evt_fire   = 1'b1;
                            evt_ch     = q_item.index;
                            evt_act    = 1'b1;
                            state_next = ST_FLUSH;
                        end
                        KIND_TICK:
                        begin
                            if (!primed_reg)
                            begin
                                // first tick: load levels only
                                last_level_next   = q_item.buttons;
                                stable_level_next = q_item.buttons;
                                for (int i = 0; i < CHANNELS; i++)
                                    debounce_count_next[i] = '0;
                                primed_next = 1'b1;
                            end
                            else
                            begin
                                buttons_next = q_item.buttons;
                                ch_next      = '0;
                                state_next   = ST_EXP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EXP:
            begin
                if (!(expire && stall))
                begin
                    cue_elapsed_next[ch_reg] = el_inc;
                    if (expire)
                    begin
                        cue_active_next[ch_reg] = 1'b0;
                        evt_fire = 1'b1;
                        evt_act  = 1'b0;
                    end
                    state_next = ST_DEB;
                end
            end
            ST_DEB:
            begin
                if (!(cue_hit && stall))
                begin
                    if (cfg.enable[ch_reg])
                    begin
                        last_level_next[ch_reg]     = lv;
                        debounce_count_next[ch_reg] = db_new;
                    end
                    else
                    begin
                        debounce_count_next[ch_reg] = db_inc;
                    end
                    if (take_stable)
                        stable_level_next[ch_reg] = lv;
                    if (cue_hit)
                    begin
                        cue_active_next[ch_reg]  = 1'b1;
                        cue_elapsed_next[ch_reg] = '0;
                        evt_fire = 1'b1;
                        evt_act  = 1'b1;
                    end
                    if (ch_reg == CH_W'(CHANNELS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = ST_EXP;
                    end
                end
            end
            ST_FLUSH:
            begin
                // release the held event as the final one of this request
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_load_last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hold each new event back in the pending register so the final one can be marked
        if (evt_fire)
        begin
            if (pend_valid_reg)
                out_load = 1'b1;
            pend_valid_next = 1'b1;
            pend_ch_next    = evt_ch;
            pend_act_next   = evt_act;
            pend_mask_next  = cue_active_next;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_ch_next    = pend_ch_reg;
            out_act_next   = pend_act_reg;
            out_mask_next  = pend_mask_reg;
            out_last_next  = out_load_last;
        end
    end

    always_ff @(posedge clk)
    begin
        buttons_reg   <= buttons_next;
        pend_ch_reg   <= pend_ch_next;
        pend_act_reg  <= pend_act_next;
        pend_mask_reg <= pend_mask_next;
        out_ch_reg    <= out_ch_next;
        out_act_reg   <= out_act_next;
        out_mask_reg  <= out_mask_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ch_reg           <= '0;
            primed_reg       <= 1'b0;
            last_level_reg   <= '0;
            stable_level_reg <= '0;
            cue_active_reg   <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                debounce_count_reg[i] <= '0;
                cue_elapsed_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg          <= state_next;
            ch_reg             <= ch_next;
            primed_reg         <= primed_next;
            last_level_reg     <= last_level_next;
            stable_level_reg   <= stable_level_next;
            cue_active_reg     <= cue_active_next;
            pend_valid_reg     <= pend_valid_next;
            out_valid_reg      <= out_valid_next;
            debounce_count_reg <= debounce_count_next;
            cue_elapsed_reg    <= cue_elapsed_next;
        end
    end

endmodule

`default_nettype wire

@@ design/debounced_cue_trigger_timer_core.sv @@
// Top level of the debounced cue trigger timer: register port, front end and back end.
`timescale 1ns / 1ps
`default_nettype none

// Four button channels, each with a debouncer and a retriggerable one-shot cue
// timer. A tick request (command 0) samples all buttons and advances time one
// unit; a software trigger request (command 1) restarts one cue. Each cue set
// or clear comes out as one event, in channel order with an expiry ahead of a
// trigger on the same channel, and last marks the final event of a request.
// Requests enter a two-deep queue; the back end takes the next one only when it
// is idle and walks the channels in turn, each with an expiry step and then a
// debounce step, and it can wait on a full event register. Registers sit at
// byte addresses 0x0 debounce_ticks, 0x4 active_ticks, 0x8 active_level, 0xC
// button_enable.
module debounced_cue_trigger_timer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic        command,
    input  wire logic [7:0]  buttons,
    input  wire logic [2:0]  trigger_index,
    output logic             evt_valid,
    input  wire logic        evt_ready,
    output logic [2:0]       event_channel,
    output logic             event_active,
    output logic [7:0]       active_mask,
    output logic             last
);
    import dctt_pkg::*;

    logic [15:0] debounce_ticks_reg, debounce_ticks_next;
    logic [23:0] active_ticks_reg, active_ticks_next;
    logic        active_level_reg, active_level_next;
    logic [7:0]  button_enable_reg, button_enable_next;
    logic        wr_en;
    cfg_t        cfg;
    logic        q_valid;
    logic        q_ready;
    item_t       q_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        debounce_ticks_next = debounce_ticks_reg;
        active_ticks_next   = active_ticks_reg;
        active_level_next   = active_level_reg;
        button_enable_next  = button_enable_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_DEBOUNCE: debounce_ticks_next = pwdata[15:0];
                REG_ACTIVE:   active_ticks_next   = pwdata[23:0];
                REG_LEVEL:    active_level_next   = pwdata[0];
                REG_ENABLE:   button_enable_next  = pwdata[7:0];
                default:      begin end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DEBOUNCE: prdata = 32'(debounce_ticks_reg);
            REG_ACTIVE:   prdata = 32'(active_ticks_reg);
            REG_LEVEL:    prdata = 32'(active_level_reg);
            REG_ENABLE:   prdata = 32'(button_enable_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= 16'd50;
            active_ticks_reg   <= 24'd3000;
            active_level_reg   <= 1'b0;
            button_enable_reg  <= 8'hFF;
        end
        else
        begin
            debounce_ticks_reg <= debounce_ticks_next;
            active_ticks_reg   <= active_ticks_next;
            active_level_reg   <= active_level_next;
            button_enable_reg  <= button_enable_next;
        end
    end

    always_comb
    begin
        cfg.debounce_ticks = debounce_ticks_reg;
        cfg.active_ticks   = active_ticks_reg;
        cfg.active_level   = active_level_reg;
        cfg.enable         = button_enable_reg[CHANNELS-1:0];
    end

    dctt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .command       (command),
        .buttons       (buttons),
        .trigger_index (trigger_index),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    dctt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .evt_valid     (evt_valid),
        .evt_ready     (evt_ready),
        .event_channel (event_channel),
        .event_active  (event_active),
        .active_mask   (active_mask),
        .last          (last)
    );

endmodule

`default_nettype wire

@@ tb/dctt_event_checker.sv @@
// Event checker for the cue trigger timer: predicts each request's events, compares, checks reads.
`timescale 1ns / 1ps

module dctt_event_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  logic        command,
    input  logic [7:0]  buttons,
    input  logic [2:0]  trigger_index,
    input  logic        evt_valid,
    input  logic        evt_ready,
    input  logic [2:0]  event_channel,
    input  logic        event_active,
    input  logic [7:0]  active_mask,
    input  logic        last,
    output int          fail_count,
    output int          outstanding,
    output int          checked
);
    import dctt_pkg::*;

    localparam int MAX_EVENTS = 8;

    typedef struct packed {
        logic [2:0] channel;
        logic       active;
        logic [7:0] mask;
        logic       last;
    } cue_event_t;

    // Register copies, updated by watching the register port
    logic [15:0] hold_ticks;
    logic [23:0] cue_ticks;
    logic        press_level;
    logic [7:0]  chan_enable;

    logic        primed;
    logic        last_lv   [CHANNELS];
    logic        stable_lv [CHANNELS];
    logic [15:0] db_count  [CHANNELS];
    logic        cue_on    [CHANNELS];
    logic [23:0] elapsed   [CHANNELS];

    cue_event_t  expected_events[$];
    cue_event_t  burst[MAX_EVENTS];
    int          burst_len;
    int          mismatches;

    function automatic logic [7:0] active_flags();
        logic [7:0] m;
        m = '0;
        for (int i = 0; i < CHANNELS; i++)
            m[i] = cue_on[i];
        return m;
    endfunction

    task automatic add_event(input int ch, input logic act);
        if (burst_len < MAX_EVENTS)
        begin
            burst[burst_len] = '{channel: 3'(ch), active: act, mask: active_flags(), last: 1'b0};
            burst_len++;
        end
    endtask

    task automatic advance_cues(input logic cmd, input logic [7:0] btn, input logic [2:0] idx);
        logic lv;
        burst_len = 0;
        if (cmd == CMD_TRIG)
        begin
            if (int'(idx) < CHANNELS)
            begin
                cue_on[idx[CH_W-1:0]]  = 1'b1;
                elapsed[idx[CH_W-1:0]] = '0;
                add_event(int'(idx), 1'b1);
            end
        end
        else if (!primed)
        begin
            // first tick only loads the levels
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_lv[i]   = btn[i];
                stable_lv[i] = btn[i];
                db_count[i]  = '0;
            end
            primed = 1'b1;
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (db_count[i] != 16'hFFFF)
                    db_count[i]++;
                if (elapsed[i] != 24'hFFFFFF)
                    elapsed[i]++;
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                lv = btn[i];
                if (cue_on[i] && elapsed[i] >= cue_ticks)
                begin
                    cue_on[i] = 1'b0;
                    add_event(i, 1'b0);
                end
                if (chan_enable[i])
                begin
                    if (lv != last_lv[i])
                    begin
                        last_lv[i]  = lv;
                        db_count[i] = '0;
                    end
                    if (db_count[i] >= hold_ticks && lv != stable_lv[i])
                    begin
                        stable_lv[i] = lv;
                        if (lv == press_level)
                        begin
                            cue_on[i]  = 1'b1;
                            elapsed[i] = '0;
                            add_event(i, 1'b1);
                        end
                    end
                end
            end
        end
        if (burst_len > 0)
            burst[burst_len-1].last = 1'b1;
        for (int k = 0; k < burst_len; k++)
            expected_events.push_back(burst[k]);
    endtask

    task automatic flag(input string msg);
        mismatches++;
        fail_count++;
        if (mismatches <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cue_event_t  seen;
        cue_event_t  want;
        logic [31:0] reg_val;
        if (!rst_n)
        begin
            hold_ticks  = 16'd50;
            cue_ticks   = 24'd3000;
            press_level = 1'b0;
            chan_enable = 8'hFF;
            primed      = 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_lv[i]   = 1'b0;
                stable_lv[i] = 1'b0;
                db_count[i]  = '0;
                cue_on[i]    = 1'b0;
                elapsed[i]   = '0;
            end
            expected_events.delete();
            burst_len   = 0;
            mismatches  = 0;
            fail_count  = 0;
            outstanding = 0;
            checked     = 0;
        end
        else
        begin
            // compare before predicting: a request never causes an event at its own edge
            if (evt_valid && evt_ready)
            begin
                seen = '{channel: event_channel, active: event_active,
                         mask: active_mask, last: last};
                checked++;
                if (expected_events.size() == 0)
                    flag($sformatf("unexpected event ch %0d active %0d mask %h last %0d",
                                   seen.channel, seen.active, seen.mask, seen.last));
                else
                begin
                    want = expected_events.pop_front();
                    if (seen !== want)
                        flag($sformatf({"event expected ch %0d active %0d mask %h last %0d,",
                                        " got ch %0d active %0d mask %h last %0d"},
                                       want.channel, want.active, want.mask, want.last,
                                       seen.channel, seen.active, seen.mask, seen.last));
                end
            end

            if (cmd_valid && cmd_ready)
                advance_cues(command, buttons, trigger_index);

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_DEBOUNCE: hold_ticks  = pwdata[15:0];
                        REG_ACTIVE:   cue_ticks   = pwdata[23:0];
                        REG_LEVEL:    press_level = pwdata[0];
                        REG_ENABLE:   chan_enable = pwdata[7:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[3:2])
                        REG_DEBOUNCE: reg_val = {16'd0, hold_ticks};
                        REG_ACTIVE:   reg_val = {8'd0, cue_ticks};
                        REG_LEVEL:    reg_val = {31'd0, press_level};
                        default:      reg_val = {24'd0, chan_enable};
                    endcase
                    if (prdata !== reg_val)
                        flag($sformatf("register at %h read %h, expected %h",
                                       paddr, prdata, reg_val));
                end
            end

            outstanding = expected_events.size();
        end
    end

endmodule

@@ tb/debounced_cue_trigger_timer_core_tb.sv @@
// Top of the debounced cue trigger timer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module debounced_cue_trigger_timer_core_tb;
    import dctt_pkg::*;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid     = 1'b0;
    logic        cmd_ready;
    logic        command       = 1'b0;
    logic [7:0]  buttons       = '0;
    logic [2:0]  trigger_index = '0;
    logic        evt_valid;
    logic        evt_ready     = 1'b0;
    logic [2:0]  event_channel;
    logic        event_active;
    logic [7:0]  active_mask;
    logic        last;

    int fail_count;
    int outstanding;
    int checked;
    int sent       = 0;
    int settings   = 0;
    int stall_left = 0;
    bit steady     = 1'b0;
    logic [CHANNELS-1:0] held = '0;

    always #5 clk = ~clk;

    debounced_cue_trigger_timer_core DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .command(command),
        .buttons(buttons), .trigger_index(trigger_index),
        .evt_valid(evt_valid), .evt_ready(evt_ready), .event_channel(event_channel),
        .event_active(event_active), .active_mask(active_mask), .last(last)
    );

    dctt_event_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .command(command),
        .buttons(buttons), .trigger_index(trigger_index),
        .evt_valid(evt_valid), .evt_ready(evt_ready), .event_channel(event_channel),
        .event_active(event_active), .active_mask(active_mask), .last(last),
        .fail_count(fail_count), .outstanding(outstanding), .checked(checked)
    );

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        if (steady || $urandom_range(0, 1) == 0)
            return 0;
        return pick_len();
    endfunction

    // Event side: random stalls, ready held high between them
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            evt_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            evt_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 20)
                stall_left = pick_len();
        end
    end

    // Entered and left at a falling edge
    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [31:0] deb, input logic [31:0] act,
                              input logic [31:0] lvl, input logic [31:0] en);
        apb_access(1'b1, REG_DEBOUNCE, deb);
        apb_access(1'b1, REG_ACTIVE, act);
        apb_access(1'b1, REG_LEVEL, lvl);
        apb_access(1'b1, REG_ENABLE, en);
        apb_access(1'b0, REG_DEBOUNCE, '0);
        apb_access(1'b0, REG_ACTIVE, '0);
        apb_access(1'b0, REG_LEVEL, '0);
        apb_access(1'b0, REG_ENABLE, '0);
        settings++;
    endtask

    task automatic send_request(input logic cmd, input logic [7:0] btn, input logic [2:0] idx,
                                input int gap);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid     <= 1'b1;
        command       <= cmd;
        buttons       <= btn;
        trigger_index <= idx;
        do @(posedge clk); while (!cmd_ready);
        @(negedge clk);
        sent++;
    endtask

    // Drop valid, wait for every predicted event, then let the back end settle
    task automatic wait_drained(input int settle);
        cmd_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic random_request();
        logic [7:0] junk;
        logic [2:0] idx;
        int         r;
        junk = 8'($urandom);
        r    = $urandom_range(0, 99);
        if (r < 15)
        begin
            if ($urandom_range(0, 9) == 0)
                idx = 3'($urandom_range(CHANNELS, 7));
            else
                idx = 3'($urandom_range(0, CHANNELS - 1));
            send_request(CMD_TRIG, junk, idx, pick_gap());
        end
        else
        begin
            // mostly held levels with an occasional edge, now and then pure noise
            if (r < 22)
                held = CHANNELS'($urandom);
            else if ($urandom_range(0, 3) == 0)
                held[CH_W'($urandom_range(0, CHANNELS - 1))] ^= 1'b1;
            junk[CHANNELS-1:0] = held;
            send_request(CMD_TICK, junk, 3'($urandom), pick_gap());
        end
    endtask

    initial
    begin
        logic [7:0] en;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of the registers
        apb_access(1'b0, REG_DEBOUNCE, '0);
        apb_access(1'b0, REG_ACTIVE, '0);
        apb_access(1'b0, REG_LEVEL, '0);
        apb_access(1'b0, REG_ENABLE, '0);

        // triggers before the first tick, out of range, priming tick, restart
        send_request(CMD_TRIG, 8'hA5, 3'd0, 0);
        send_request(CMD_TRIG, 8'h00, 3'd7, 0);
        send_request(CMD_TRIG, 8'h00, 3'(CHANNELS), 1);
        send_request(CMD_TICK, 8'hF0, 3'd0, 0);
        send_request(CMD_TRIG, 8'h00, 3'(CHANNELS - 1), 0);
        send_request(CMD_TRIG, 8'h00, 3'(CHANNELS - 1), 2);
        send_request(CMD_TICK, 8'hFF, 3'd0, 0);
        wait_drained(40);

        // zero durations, active high
        set_config(32'd0, 32'd0, 32'd1, 32'hFF);
        send_request(CMD_TICK, 8'h0F, 3'd0, 0);
        send_request(CMD_TICK, 8'h0F, 3'd0, 0);
        send_request(CMD_TICK, 8'h00, 3'd0, 0);
        send_request(CMD_TRIG, 8'hFF, 3'd2, 0);
        send_request(CMD_TICK, 8'h00, 3'd5, 0);
        wait_drained(40);

        // full-scale writes, upper bits masked off
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_TICK, 8'h00, 3'd0, 0);
        send_request(CMD_TRIG, 8'h00, 3'd1, 0);
        send_request(CMD_TICK, 8'h0F, 3'd0, 0);
        wait_drained(40);

        // two channels disabled, short timers
        set_config(32'd2, 32'd3, 32'd0, 32'h35);
        send_request(CMD_TICK, 8'h0F, 3'd0, 0);
        send_request(CMD_TICK, 8'h0F, 3'd0, 0);
        send_request(CMD_TICK, 8'h0F, 3'd0, 0);
        send_request(CMD_TRIG, 8'h00, 3'd1, 0);
        send_request(CMD_TICK, 8'hF0, 3'd0, 0);
        send_request(CMD_TICK, 8'hF0, 3'd0, 0);
        send_request(CMD_TICK, 8'hF0, 3'd0, 0);
        send_request(CMD_TICK, 8'hF0, 3'd0, 0);

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_drained(40);
            if ($urandom_range(0, 2) == 0)
                en = 8'($urandom);
            else
                en = {4'($urandom), 4'hF};
            set_config(32'($urandom_range(0, 4)), 32'($urandom_range(0, 12)),
                       32'($urandom_range(0, 1)), {24'd0, en});
            steady = (ph == 2);
            for (int n = 0; n < 40; n++)
            begin
                // hold the sender until the event side has caught up
                if (ph == 1 && n == 20)
                    wait_drained(0);
                random_request();
            end
        end

        wait_drained(40);
        $display("Run covered %0d requests under %0d register settings, zero and full scale too.",
                 sent, settings);
        $display("%0d events compared, %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
design/dctt_pkg.sv
design/dctt_front.sv
design/dctt_back.sv
design/debounced_cue_trigger_timer_core.sv
tb/dctt_event_checker.sv
tb/debounced_cue_trigger_timer_core_tb.sv
